[design/fsp_pkg.sv]
// ----------------------------------------------------------------------------
// fsp_pkg: shared types, constants and functions of the format spec parser
//
// Holds the item structs of both channels, the parse phase codes, the
// character codes the parser recognizes and the digit accumulation helper.
// ----------------------------------------------------------------------------
package fsp_pkg;

    // Accumulator width for width and precision; they saturate at all ones.
    localparam int NUM_BITS = 16;
    localparam int ACC_W    = NUM_BITS + 4;
    localparam logic [NUM_BITS-1:0] ACC_MAX = '1;

    // One input item: one character of a directive.
    typedef struct packed {
        logic       begin_req;
        logic [7:0] ch;
    } fsp_req_t;

    // One result item: the decoded directive record.
    typedef struct packed {
        logic        alt_form;
        logic        space_sign;
        logic        zero_pad;
        logic        left_justify;
        logic        plus_sign;
        logic        has_dot;
        logic [15:0] field_width;
        logic [15:0] field_precision;
        logic [2:0]  length_code;
        logic [3:0]  conversion;
        logic        char_consumed;
    } fsp_rsp_t;

    // Flags collected while a directive is parsed.
    typedef struct packed {
        logic dot;
        logic plus;
        logic left;
        logic zero;
        logic space;
        logic hash;
    } fsp_flags_t;

    // Parse phase codes.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_FLAGS = 3'd1;
    localparam logic [2:0] PH_WIDTH = 3'd2;
    localparam logic [2:0] PH_PREC  = 3'd3;
    localparam logic [2:0] PH_LEN_H = 3'd4;
    localparam logic [2:0] PH_LEN_L = 3'd5;
    localparam logic [2:0] PH_CONV  = 3'd6;

    // Length modifier codes.
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_H    = 3'd1;
    localparam logic [2:0] LEN_HH   = 3'd2;
    localparam logic [2:0] LEN_L    = 3'd3;
    localparam logic [2:0] LEN_LL   = 3'd4;

    // Conversion codes.
    localparam logic [3:0] CONV_NONE    = 4'd0;
    localparam logic [3:0] CONV_STR     = 4'd1;
    localparam logic [3:0] CONV_CHAR    = 4'd2;
    localparam logic [3:0] CONV_PTR     = 4'd3;
    localparam logic [3:0] CONV_DEC     = 4'd4;
    localparam logic [3:0] CONV_OCT     = 4'd5;
    localparam logic [3:0] CONV_UNS     = 4'd6;
    localparam logic [3:0] CONV_HEX_LO  = 4'd7;
    localparam logic [3:0] CONV_HEX_UP  = 4'd8;
    localparam logic [3:0] CONV_BIN     = 4'd9;
    localparam logic [3:0] CONV_PERCENT = 4'd10;

    // Character codes.
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_L_LO    = 8'h6C;
    localparam logic [7:0] CH_H_LO    = 8'h68;
    localparam logic [7:0] CH_S_LO    = 8'h73;
    localparam logic [7:0] CH_S_UP    = 8'h53;
    localparam logic [7:0] CH_C_LO    = 8'h63;
    localparam logic [7:0] CH_C_UP    = 8'h43;
    localparam logic [7:0] CH_P_LO    = 8'h70;
    localparam logic [7:0] CH_P_UP    = 8'h50;
    localparam logic [7:0] CH_D_LO    = 8'h64;
    localparam logic [7:0] CH_D_UP    = 8'h44;
    localparam logic [7:0] CH_I_LO    = 8'h69;
    localparam logic [7:0] CH_I_UP    = 8'h49;
    localparam logic [7:0] CH_O_LO    = 8'h6F;
    localparam logic [7:0] CH_O_UP    = 8'h4F;
    localparam logic [7:0] CH_U_LO    = 8'h75;
    localparam logic [7:0] CH_U_UP    = 8'h55;
    localparam logic [7:0] CH_X_LO    = 8'h78;
    localparam logic [7:0] CH_X_UP    = 8'h58;
    localparam logic [7:0] CH_B_LO    = 8'h62;
    localparam logic [7:0] CH_B_UP    = 8'h42;

    // Map a conversion letter to its code; unknown letters give none.
    function automatic logic [3:0] conv_code(input logic [7:0] ch);
        logic [3:0] code;
        case (ch) inside
            CH_S_LO, CH_S_UP:                   code = CONV_STR;
            CH_C_LO, CH_C_UP:                   code = CONV_CHAR;
            CH_P_LO, CH_P_UP:                   code = CONV_PTR;
            CH_D_LO, CH_D_UP, CH_I_LO, CH_I_UP: code = CONV_DEC;
            CH_O_LO, CH_O_UP:                   code = CONV_OCT;
            CH_U_LO, CH_U_UP:                   code = CONV_UNS;
            CH_X_LO:                            code = CONV_HEX_LO;
            CH_X_UP:                            code = CONV_HEX_UP;
            CH_B_LO, CH_B_UP:                   code = CONV_BIN;
            CH_PERCENT:                         code = CONV_PERCENT;
            default:                            code = CONV_NONE;
        endcase
        return code;
    endfunction

    // Times ten plus one decimal digit, saturating at all ones.
    function automatic logic [NUM_BITS-1:0] acc_digit(input logic [NUM_BITS-1:0] acc,
                                                      input logic [7:0]          ch);
        logic [ACC_W-1:0] wide;
        logic [ACC_W-1:0] sum;
        logic [3:0]       dig;
        dig  = 4'(ch - CH_ZERO);
        wide = ACC_W'(acc);
        sum  = (wide << 3) + (wide << 1) + ACC_W'(dig);
        return (sum > ACC_W'(ACC_MAX)) ? ACC_MAX : sum[NUM_BITS-1:0];
    endfunction

endpackage

[design/fsp_in_reg.sv]
// ----------------------------------------------------------------------------
// fsp_in_reg: input register of the format spec parser
//
// Captures one character item and holds it until the parse core takes it.
// ----------------------------------------------------------------------------
module fsp_in_reg import fsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  fsp_req_t req,
    input  logic     take,
    output logic     item_valid,
    output fsp_req_t item
);

    logic     valid_reg;
    logic     valid_next;
    fsp_req_t item_reg;

    // The register frees up in the same cycle the core takes its item.
    assign req_ready = !valid_reg || take;

    always_comb
    begin
        if (req_valid && req_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload loads on every accepted item and needs no reset.
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg <= req;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[design/fsp_core.sv]
// ----------------------------------------------------------------------------
// fsp_core: parse state and single-step update of the format spec parser
//
// Holds the directive state and works out, for the item at its input, the
// next state and whether that character closes the directive.
// ----------------------------------------------------------------------------
module fsp_core import fsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  fsp_req_t item,
    input  logic     step,
    output logic     emit,
    output fsp_rsp_t rsp
);

    logic [2:0]          phase_reg;
    logic [2:0]          phase_next;
    fsp_flags_t          flags_reg;
    fsp_flags_t          flags_next;
    logic [NUM_BITS-1:0] width_reg;
    logic [NUM_BITS-1:0] width_next;
    logic [NUM_BITS-1:0] prec_reg;
    logic [NUM_BITS-1:0] prec_next;
    logic [2:0]          len_reg;
    logic [2:0]          len_next;

    logic [2:0]          cur_phase;
    fsp_flags_t          cur_flags;
    logic [NUM_BITS-1:0] cur_width;
    logic [NUM_BITS-1:0] cur_prec;
    logic [2:0]          cur_len;
    logic [7:0]          ch;
    logic                is_digit;
    logic                is_flag;
    logic                tail;
    logic                finish;

    assign ch       = item.ch;
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_flag  = (ch == CH_HASH) || (ch == CH_SPACE) || (ch == CH_ZERO) ||
                      (ch == CH_MINUS) || (ch == CH_PLUS);

    // A begin item drops any unfinished directive and starts from clean state.
    always_comb
    begin
        if (item.begin_req)
        begin
            cur_phase = PH_FLAGS;
            cur_flags = '0;
            cur_width = '0;
            cur_prec  = '0;
            cur_len   = LEN_NONE;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_flags = flags_reg;
            cur_width = width_reg;
            cur_prec  = prec_reg;
            cur_len   = len_reg;
        end
    end

    // One parse step for the current character.
    always_comb
    begin
        phase_next = cur_phase;
        flags_next = cur_flags;
        width_next = cur_width;
        prec_next  = cur_prec;
        len_next   = cur_len;
        tail       = 1'b0;
        finish     = 1'b0;

        unique case (cur_phase) inside
            PH_FLAGS, PH_WIDTH:
            begin
                if (cur_phase == PH_FLAGS && is_flag)
                begin
                    flags_next.hash  = cur_flags.hash  | (ch == CH_HASH);
                    flags_next.space = cur_flags.space | (ch == CH_SPACE);
                    flags_next.zero  = cur_flags.zero  | (ch == CH_ZERO);
                    flags_next.left  = cur_flags.left  | (ch == CH_MINUS);
                    flags_next.plus  = cur_flags.plus  | (ch == CH_PLUS);
                end
                else if (is_digit)
                begin
                    width_next = acc_digit(cur_width, ch);
                    phase_next = PH_WIDTH;
                end
                else if (ch == CH_DOT)
                begin
                    flags_next.dot  = 1'b1;
                    flags_next.zero = 1'b0;
                    phase_next      = PH_PREC;
                end
                else
                begin
                    tail = 1'b1;
                end
            end
            PH_PREC:
            begin
                if (is_digit)
                begin
                    prec_next = acc_digit(cur_prec, ch);
                end
                else
                begin
                    tail = 1'b1;
                end
            end
            PH_LEN_L:
            begin
                if (ch == CH_L_LO)
                begin
                    len_next   = LEN_LL;
                    phase_next = PH_CONV;
                end
                else
                begin
                    len_next = LEN_L;
                    finish   = 1'b1;
                end
            end
            PH_LEN_H:
            begin
                if (ch == CH_H_LO)
                begin
                    len_next   = LEN_HH;
                    phase_next = PH_CONV;
                end
                else
                begin
                    len_next = LEN_H;
                    finish   = 1'b1;
                end
            end
            PH_CONV:
            begin
                finish = 1'b1;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // A length letter or the conversion itself after flags, width or precision.
        if (tail)
        begin
            if (ch == CH_L_LO)
            begin
                phase_next = PH_LEN_L;
            end
            else if (ch == CH_H_LO)
            begin
                phase_next = PH_LEN_H;
            end
            else
            begin
                finish = 1'b1;
            end
        end

        if (finish)
        begin
            phase_next = PH_IDLE;
        end
    end

    // Directive record built from the state as it stands after this character.
    always_comb
    begin
        rsp.alt_form        = flags_next.hash;
        rsp.space_sign      = flags_next.space;
        rsp.zero_pad        = flags_next.zero && !flags_next.left && !flags_next.dot;
        rsp.left_justify    = flags_next.left;
        rsp.plus_sign       = flags_next.plus;
        rsp.has_dot         = flags_next.dot;
        rsp.field_width     = 16'(width_next);
        rsp.field_precision = 16'(prec_next);
        rsp.length_code     = len_next;
        rsp.conversion      = conv_code(ch);
        rsp.char_consumed   = (conv_code(ch) != CONV_NONE);
    end

    assign emit = item_valid && finish;

    // State advances only when the item is actually taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            flags_reg <= '0;
            width_reg <= '0;
            prec_reg  <= '0;
            len_reg   <= LEN_NONE;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            width_reg <= width_next;
            prec_reg  <= prec_next;
            len_reg   <= len_next;
        end
    end

endmodule

[design/fsp_out_reg.sv]
// ----------------------------------------------------------------------------
// fsp_out_reg: result register of the format spec parser
//
// Holds one directive record until the downstream side takes it.
// ----------------------------------------------------------------------------
module fsp_out_reg import fsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  fsp_rsp_t load_rsp,
    output logic     free,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output fsp_rsp_t rsp
);

    logic     valid_reg;
    logic     valid_next;
    fsp_rsp_t rsp_reg;

    // The slot can take a new record when empty or being drained this cycle.
    assign free = !valid_reg || rsp_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= load_rsp;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule

[design/format_spec_parser_top.sv]
// ----------------------------------------------------------------------------
// format_spec_parser_top: printf-style directive parser
//
// Parses the characters after a percent sign and emits one directive record
// when the conversion character arrives.
// ----------------------------------------------------------------------------
// The parser takes one character item per clock cycle, back to back, and
// returns a directive record through the input register and then the result
// register once the closing character is accepted. The rate is set by the
// parse step, whose longest path is the times-ten-plus-digit update of the
// width or precision accumulator. An item that closes a directive waits in
// the input register only while the result register still holds an untaken
// record; other characters never wait there.
module format_spec_parser_top import fsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  fsp_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output fsp_rsp_t rsp
);

    logic     item_valid;
    fsp_req_t item;
    logic     emit;
    fsp_rsp_t core_rsp;
    logic     free;
    logic     step;

    // An item is processed unless it closes a directive and the slot is full.
    assign step = item_valid && (!emit || free);

    fsp_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    fsp_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .step       (step),
        .emit       (emit),
        .rsp        (core_rsp)
    );

    fsp_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && emit),
        .load_rsp  (core_rsp),
        .free      (free),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

[design/fsp_checker.sv]
// ----------------------------------------------------------------------------
// fsp_checker: port-level checks for the format spec parser
//
// Watches the top-level ports and checks the result channel and the
// consistency of each directive record.
// ----------------------------------------------------------------------------
module fsp_checker import fsp_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input fsp_rsp_t rsp
);

    // A stalled record stays put until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    // The consumed flag follows from the conversion code.
    a_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.char_consumed == (rsp.conversion != CONV_NONE)))
        else $error("char_consumed disagrees with conversion");

    // Zero padding never survives a dot or left justification.
    a_zero_pad: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.zero_pad && (rsp.left_justify || rsp.has_dot)))
        else $error("zero_pad set together with dot or left justify");

    // Without a dot there is no precision.
    a_prec: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.has_dot |-> rsp.field_precision == 16'd0)
        else $error("precision set without a dot");

    // Only defined length and conversion codes appear.
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.length_code <= LEN_LL) && (rsp.conversion <= CONV_PERCENT))
        else $error("length or conversion code out of range");

endmodule

bind format_spec_parser_top fsp_checker u_fsp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

[bench/fsp_directive_checker.sv]
// ----------------------------------------------------------------------------
// fsp_directive_checker: directive record checker for the format spec parser
//
// Watches both channels of the parser. Every accepted character item is run
// through a cycle-free copy of the directive parse, and each directive that
// closes queues its record. Every accepted result item is compared field by
// field with the oldest queued record.
// ----------------------------------------------------------------------------
module fsp_directive_checker import fsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_ready,
    input  fsp_req_t req,
    input  logic     rsp_valid,
    input  logic     rsp_ready,
    input  fsp_rsp_t rsp,
    output int       mismatches,
    output int       records_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Parse state of the predicted directive.
    logic [2:0]          parse_phase = PH_IDLE;
    fsp_flags_t          seen_flags  = '0;
    logic [NUM_BITS-1:0] width_sum   = '0;
    logic [NUM_BITS-1:0] prec_sum    = '0;
    logic [2:0]          length_sel  = LEN_NONE;

    // Records of closed directives that the parser still owes.
    fsp_rsp_t            expected_records[$];
    fsp_rsp_t            oldest_record;
    int                  error_total = 0;

    // Prints one line per mismatch and keeps the count.
    task automatic report_mismatch(input string what);
        $display("%0t ns: directive mismatch: %s", $time, what);
        error_total++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is %0d, should be %0d", name, got, want));
        end
    endtask

    // Times ten plus one digit, held at all ones once it overflows.
    function automatic logic [NUM_BITS-1:0] scale_in_digit(input logic [NUM_BITS-1:0] acc,
                                                           input logic [7:0] c);
        longint unsigned grown;
        grown = acc;
        grown = grown * 10 + (c - CH_ZERO);
        return (grown > ACC_MAX) ? ACC_MAX : grown[NUM_BITS-1:0];
    endfunction

    // Conversion letter to its code; anything else is none.
    function automatic logic [3:0] letter_code(input logic [7:0] c);
        case (c)
            CH_S_LO, CH_S_UP:                   return CONV_STR;
            CH_C_LO, CH_C_UP:                   return CONV_CHAR;
            CH_P_LO, CH_P_UP:                   return CONV_PTR;
            CH_D_LO, CH_D_UP, CH_I_LO, CH_I_UP: return CONV_DEC;
            CH_O_LO, CH_O_UP:                   return CONV_OCT;
            CH_U_LO, CH_U_UP:                   return CONV_UNS;
            CH_X_LO:                            return CONV_HEX_LO;
            CH_X_UP:                            return CONV_HEX_UP;
            CH_B_LO, CH_B_UP:                   return CONV_BIN;
            CH_PERCENT:                         return CONV_PERCENT;
            default:                            return CONV_NONE;
        endcase
    endfunction

    // One character through the parse; a closing character queues a record.
    task automatic step_parser(input fsp_req_t item);
        logic [7:0] c;
        logic       to_tail;
        logic       close;
        logic       is_digit;
        fsp_rsp_t   rec;
        c        = item.ch;
        to_tail  = 1'b0;
        close    = 1'b0;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

        // A begin drops whatever directive was open and starts a new one.
        if (item.begin_req)
        begin
            seen_flags  = '0;
            width_sum   = '0;
            prec_sum    = '0;
            length_sel  = LEN_NONE;
            parse_phase = PH_FLAGS;
        end

        case (parse_phase)
            PH_FLAGS, PH_WIDTH:
            begin
                if (parse_phase == PH_FLAGS && (c == CH_HASH || c == CH_SPACE ||
                    c == CH_ZERO || c == CH_MINUS || c == CH_PLUS))
                begin
                    seen_flags.hash  |= (c == CH_HASH);
                    seen_flags.space |= (c == CH_SPACE);
                    seen_flags.zero  |= (c == CH_ZERO);
                    seen_flags.left  |= (c == CH_MINUS);
                    seen_flags.plus  |= (c == CH_PLUS);
                end
                else if (is_digit)
                begin
                    width_sum   = scale_in_digit(width_sum, c);
                    parse_phase = PH_WIDTH;
                end
                else if (c == CH_DOT)
                begin
                    seen_flags.dot  = 1'b1;
                    seen_flags.zero = 1'b0;
                    parse_phase     = PH_PREC;
                end
                else
                begin
                    to_tail = 1'b1;
                end
            end
            PH_PREC:
            begin
                if (is_digit)
                begin
                    prec_sum = scale_in_digit(prec_sum, c);
                end
                else
                begin
                    to_tail = 1'b1;
                end
            end
            PH_LEN_L:
            begin
                if (c == CH_L_LO)
                begin
                    length_sel  = LEN_LL;
                    parse_phase = PH_CONV;
                end
                else
                begin
                    length_sel = LEN_L;
                    close      = 1'b1;
                end
            end
            PH_LEN_H:
            begin
                if (c == CH_H_LO)
                begin
                    length_sel  = LEN_HH;
                    parse_phase = PH_CONV;
                end
                else
                begin
                    length_sel = LEN_H;
                    close      = 1'b1;
                end
            end
            PH_CONV:
            begin
                close = 1'b1;
            end
            default:
            begin
                parse_phase = PH_IDLE;
            end
        endcase

        // After flags, width or precision: a length letter or the conversion.
        if (to_tail)
        begin
            if (c == CH_L_LO)
            begin
                parse_phase = PH_LEN_L;
            end
            else if (c == CH_H_LO)
            begin
                parse_phase = PH_LEN_H;
            end
            else
            begin
                close = 1'b1;
            end
        end

        if (close)
        begin
            rec.alt_form        = seen_flags.hash;
            rec.space_sign      = seen_flags.space;
            rec.zero_pad        = seen_flags.zero & ~seen_flags.left & ~seen_flags.dot;
            rec.left_justify    = seen_flags.left;
            rec.plus_sign       = seen_flags.plus;
            rec.has_dot         = seen_flags.dot;
            rec.field_width     = width_sum[15:0];
            rec.field_precision = prec_sum[15:0];
            rec.length_code     = length_sel;
            rec.conversion      = letter_code(c);
            rec.char_consumed   = (rec.conversion != CONV_NONE);
            expected_records.push_back(rec);
            parse_phase = PH_IDLE;
        end
    endtask

    task automatic compare_record(input fsp_rsp_t got, input fsp_rsp_t want);
        check_field("alt_form", got.alt_form, want.alt_form);
        check_field("space_sign", got.space_sign, want.space_sign);
        check_field("zero_pad", got.zero_pad, want.zero_pad);
        check_field("left_justify", got.left_justify, want.left_justify);
        check_field("plus_sign", got.plus_sign, want.plus_sign);
        check_field("has_dot", got.has_dot, want.has_dot);
        check_field("field_width", got.field_width, want.field_width);
        check_field("field_precision", got.field_precision, want.field_precision);
        check_field("length_code", got.length_code, want.length_code);
        check_field("conversion", got.conversion, want.conversion);
        check_field("char_consumed", got.char_consumed, want.char_consumed);
    endtask

    // Both channels are sampled at the clock edge where the handshake completes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase = PH_IDLE;
            seen_flags  = '0;
            width_sum   = '0;
            prec_sum    = '0;
            length_sel  = LEN_NONE;
            expected_records.delete();
            records_pending <= 0;
            mismatches      <= error_total;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                step_parser(req);
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_records.size() == 0)
                begin
                    report_mismatch("record arrived with no directive closed");
                end
                else
                begin
                    oldest_record = expected_records.pop_front();
                    compare_record(rsp, oldest_record);
                end
            end
            records_pending <= expected_records.size();
            mismatches      <= error_total;
        end
    end

endmodule

[bench/format_spec_parser_top_tb.sv]
// ----------------------------------------------------------------------------
// format_spec_parser_top_tb: regression for the format spec parser
//
// Feeds directive characters, first a short hand-picked set and then random
// directives mixed with stray and broken ones, with random idle gaps on the
// character side and random stalls on the record side. The checker beside
// the parser predicts and compares every record.
// ----------------------------------------------------------------------------
module format_spec_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fsp_pkg::*;

    localparam int ITEM_TARGET = 550;

    // Conversion letters the parser knows, percent included.
    localparam logic [7:0] CONV_LETTERS [23] = '{
        CH_S_LO, CH_S_UP, CH_C_LO, CH_C_UP, CH_P_LO, CH_P_UP, CH_D_LO, CH_D_UP,
        CH_I_LO, CH_I_UP, CH_O_LO, CH_O_UP, CH_U_LO, CH_U_UP, CH_X_LO, CH_X_UP,
        CH_B_LO, CH_B_UP, CH_PERCENT, CH_S_LO, CH_D_LO, CH_X_LO, CH_U_LO
    };
    localparam logic [7:0] FLAG_CHARS [5] = '{CH_HASH, CH_SPACE, CH_ZERO, CH_MINUS, CH_PLUS};

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    fsp_req_t req;
    logic     rsp_valid;
    logic     rsp_ready;
    fsp_rsp_t rsp;
    int       mismatches;
    int       records_pending;
    logic     steady_flow;
    int       items_sent;

    format_spec_parser_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    fsp_directive_checker directive_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req             (req),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .rsp             (rsp),
        .mismatches      (mismatches),
        .records_pending (records_pending)
    );

    // 12 ns clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Idle length: mostly none, sometimes a few cycles, rarely a long one.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_flow || roll < 60)
        begin
            return 0;
        end
        return (roll < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    // Offers one character item, holds it until taken, then maybe idles.
    task automatic send_char(input logic first, input logic [7:0] c);
        int gap;
        req_valid     <= 1'b1;
        req.begin_req <= first;
        req.ch        <= c;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        gap = idle_length();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_string(input string text);
        for (int i = 0; i < text.len(); i++)
        begin
            send_char(i == 0, text[i]);
            items_sent++;
        end
    endtask

    // Holds off the sender until every closed directive has its record.
    task automatic drain_records();
        req_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (records_pending != 0);
    endtask

    // One random directive: flags, width, precision, length, conversion.
    // A few lose their tail so the next begin lands mid-directive.
    task automatic send_directive();
        logic [7:0] text[$];
        int         count;
        int         roll;
        count = $urandom_range(0, 3);
        repeat (count) text.push_back(FLAG_CHARS[$urandom_range(0, 4)]);
        roll  = $urandom_range(0, 9);
        count = (roll < 3) ? 0 : (roll < 9) ? $urandom_range(1, 3) : $urandom_range(6, 7);
        repeat (count) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 1))
        begin
            text.push_back(CH_DOT);
            roll  = $urandom_range(0, 9);
            count = (roll < 3) ? 0 : (roll < 9) ? $urandom_range(1, 3) : $urandom_range(6, 7);
            repeat (count) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        case ($urandom_range(0, 6))
            3: text.push_back(CH_H_LO);
            4: begin text.push_back(CH_H_LO); text.push_back(CH_H_LO); end
            5: text.push_back(CH_L_LO);
            6: begin text.push_back(CH_L_LO); text.push_back(CH_L_LO); end
            default: ;
        endcase
        if ($urandom_range(0, 99) < 85)
        begin
            text.push_back(CONV_LETTERS[$urandom_range(0, 22)]);
        end
        else
        begin
            text.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0 && text.size() > 1)
        begin
            repeat ($urandom_range(1, text.size() - 1)) void'(text.pop_back());
        end
        foreach (text[i])
        begin
            send_char(i == 0, text[i]);
            items_sent++;
        end
    endtask

    // Record side: ready with random stalls, none while steady_flow is set.
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0 && !steady_flow)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready  <= 1'b1;
                stall_left = ($urandom_range(0, 3) == 0) ? idle_length() : 0;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int roll;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        steady_flow = 1'b0;
        items_sent  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Stray character while idle, then hash, space, plus and zero flags with ll and decimal.
        send_char(1'b0, CH_X_LO);
        send_string("# +0lld");
        // Width past the maximum, single h before the conversion.
        send_string("70000hu");
        // A begin in the middle drops the open directive.
        send_char(1'b1, CH_MINUS);
        send_char(1'b0, CH_DOT);
        send_string("%");
        // NUL after a zero flag, and an unknown letter after a single l, close without a code.
        send_char(1'b1, CH_ZERO);
        send_char(1'b0, 8'h00);
        send_string("lq");
        // Dot clears zero padding.
        send_string("0.5X");
        drain_records();

        // Random directives with stray characters and random begins mixed in.
        while (items_sent < ITEM_TARGET)
        begin
            steady_flow <= (items_sent >= 200 && items_sent < 280);
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    send_char(1'b0, 8'($urandom_range(0, 255)));
                    items_sent++;
                end
            end
            else if (roll < 14)
            begin
                send_char(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                items_sent++;
            end
            else
            begin
                send_directive();
            end
            if (roll >= 97)
            begin
                drain_records();
            end
        end

        drain_records();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Hang guard.
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
design/fsp_pkg.sv
design/fsp_in_reg.sv
design/fsp_core.sv
design/fsp_out_reg.sv
design/format_spec_parser_top.sv
design/fsp_checker.sv
bench/fsp_directive_checker.sv
bench/format_spec_parser_top_tb.sv
